/* rtl/pidf_pkg.sv */
// ----------------------------------------------------------------------------
// pidf_pkg
// Types, register indexes and shared constants of the filtered-D PID regulator.
// ----------------------------------------------------------------------------
package pidf_pkg;

    // default width of the internal data path (state and products)
    localparam int DATA_WIDTH_DEF = 32;

    // gains are Q12.20
    localparam int GAIN_FRAC = 20;
    // the shared multiplier takes the data operand in two slices, low slice first
    localparam int LO_BITS   = 24;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd5;

    // input commands
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_PRESET = 1'b1;

    // product being formed by the shared multiplier
    localparam logic [1:0] PH_ERR  = 2'd0;   // (meas - setpoint) * error_gain
    localparam logic [1:0] PH_INT  = 2'd1;   // err * integ_gain
    localparam logic [1:0] PH_PROP = 2'd2;   // err * prop_gain
    localparam logic [1:0] PH_DER  = 2'd3;   // deriv * deriv_gain

    // input beat
    typedef struct packed {
        logic               cmd;
        logic signed [31:0] value;
    } in_item_t;

    // result beat
    typedef struct packed {
        logic signed [31:0] drive;
        logic               saturated;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic       accept;    // input beat taken this cycle
        logic       mul_lo;    // low slice product
        logic       mul_hi;    // high slice product, low one moves to accumulator
        logic       mul_fin;   // combine, scale, saturate, write back
        logic       dfilt;     // derivative filter and last error update
        logic       sum_out;   // output sum into the result register
        logic [1:0] phase;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;        // result register can take a new beat
    } sts_t;

endpackage

/* rtl/pidf_ctrl.sv */
// ----------------------------------------------------------------------------
// pidf_ctrl
// Sequencer: steps the shared multiplier through the four products of an
// update and issues the filter and output steps.
// ----------------------------------------------------------------------------
module pidf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_cmd,
    output logic           s_ready,
    input  pidf_pkg::sts_t sts,
    output pidf_pkg::ctl_t ctl
);
    import pidf_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MLO   = 3'd1;
    localparam logic [2:0] ST_MHI   = 3'd2;
    localparam logic [2:0] ST_MSAT  = 3'd3;
    localparam logic [2:0] ST_DFILT = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        ctl         = '0;
        ctl.phase   = phase_reg;
        ctl.accept  = accept;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_cmd == CMD_UPDATE) begin
                    state_next = ST_MLO;
                    phase_next = PH_ERR;
                end
            end
            ST_MLO: begin
                ctl.mul_lo = 1'b1;
                state_next = ST_MHI;
            end
            ST_MHI: begin
                ctl.mul_hi = 1'b1;
                state_next = ST_MSAT;
            end
            ST_MSAT: begin
                ctl.mul_fin = 1'b1;
                unique case (phase_reg)
                    PH_ERR:  state_next = ST_DFILT;
                    PH_INT: begin
                        phase_next = PH_PROP;
                        state_next = ST_MLO;
                    end
                    PH_PROP: begin
                        phase_next = PH_DER;
                        state_next = ST_MLO;
                    end
                    default: state_next = ST_SUM;
                endcase
            end
            ST_DFILT: begin
                ctl.dfilt  = 1'b1;
                phase_next = PH_INT;
                state_next = ST_MLO;
            end
            ST_SUM: begin
                // hold here while the previous result is still waiting
                if (sts.out_free) begin
                    ctl.sum_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_ERR;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

/* rtl/pidf_datapath.sv */
// ----------------------------------------------------------------------------
// pidf_datapath
// Configuration registers, regulator state, shared two-pass multiplier,
// saturation and clamp logic, and the result register.
// ----------------------------------------------------------------------------
module pidf_datapath #(
    parameter int DATA_WIDTH = pidf_pkg::DATA_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pidf_pkg::ctl_t                   ctl,
    output pidf_pkg::sts_t                   sts,
    input  pidf_pkg::in_item_t               s_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pidf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output pidf_pkg::out_item_t              m_data
);
    import pidf_pkg::*;

    localparam int DW   = DATA_WIDTH;
    // operand width: holds a 33-bit raw error or a DW-bit state value
    localparam int A_W  = (DW > 33) ? DW : 33;
    localparam int HI_W = A_W - LO_BITS;
    localparam int M_W  = LO_BITS + 1 + 32;          // one slice product
    localparam int P_W  = A_W + 32;                  // full product
    localparam int SH_W = P_W - GAIN_FRAC;           // product after scaling
    localparam int CW   = ((DW > 32) ? DW : 32) + 1; // clamp compare width
    localparam int EW   = (DW > 32) ? DW : 32;       // drive limit width

    localparam logic signed [DW-1:0] MAX_D  = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MIN_D  = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [31:0]   MAX_32 = 32'sh7fff_ffff;
    localparam logic signed [31:0]   MIN_32 = 32'sh8000_0000;

    // configuration
    logic signed [31:0] setpoint_reg, err_gain_reg, prop_gain_reg;
    logic signed [31:0] integ_gain_reg, deriv_gain_reg;
    logic        [30:0] integ_limit_reg;

    // regulator state and scratch
    logic signed [DW-1:0]  last_reg, integ_reg, deriv_reg;
    logic signed [DW-1:0]  err_reg, pterm_reg, dterm_reg;
    logic signed [A_W-1:0] diff_reg;
    logic                  flag_reg;

    // multiplier
    logic signed [M_W-1:0] prod_reg, acc_reg;
    logic signed [A_W-1:0] opa;
    logic signed [31:0]    gain;
    logic signed [HI_W-1:0] a_hi;
    logic signed [LO_BITS:0] mul_a;
    logic signed [M_W-1:0] mul_p;
    logic signed [P_W-1:0] full;
    logic signed [SH_W-1:0] scaled;
    logic signed [DW-1:0]  res;
    logic                  res_ovf;

    // other arithmetic
    logic signed [A_W-1:0]  v_ext;
    logic signed [DW-1:0]   preset_val;
    logic signed [DW+1:0]   dsum, dhalf;
    logic signed [DW-1:0]   deriv_new;
    logic signed [DW:0]     isum;
    logic signed [DW-1:0]   isat, integ_new;
    logic signed [CW-1:0]   i_c, lim_c, nlim_c;
    logic signed [DW+1:0]   ssum;
    logic signed [DW-1:0]   ssat;
    logic                   s_ovf;
    logic signed [EW-1:0]   s_e;
    logic signed [31:0]     drive;
    logic                   d_ovf;
    logic                   m_valid_reg;
    out_item_t              m_data_reg;

    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
    assign sts.out_free = !m_valid_reg || m_ready;

    // operand and gain for the current product
    always_comb begin
        case (ctl.phase)
            PH_ERR: begin
                opa  = diff_reg;
                gain = err_gain_reg;
            end
            PH_INT: begin
                opa  = A_W'(err_reg);
                gain = integ_gain_reg;
            end
            PH_PROP: begin
                opa  = A_W'(err_reg);
                gain = prop_gain_reg;
            end
            default: begin
                opa  = A_W'(deriv_reg);
                gain = deriv_gain_reg;
            end
        endcase
    end

    // one multiplier for both slices: low slice unsigned, high slice signed
    assign a_hi  = opa[A_W-1:LO_BITS];
    assign mul_a = ctl.mul_hi ? (LO_BITS + 1)'(a_hi)
                              : $signed({1'b0, opa[LO_BITS-1:0]});
    assign mul_p = mul_a * gain;

    // combine slices, floor-shift by the gain fraction, saturate
    assign full    = P_W'(acc_reg) + (P_W'(prod_reg) <<< LO_BITS);
    assign scaled  = SH_W'(full >>> GAIN_FRAC);
    always_comb begin
        res_ovf = 1'b0;
        res     = DW'(scaled);
        if (scaled > SH_W'(MAX_D)) begin
            res     = MAX_D;
            res_ovf = 1'b1;
        end else if (scaled < SH_W'(MIN_D)) begin
            res     = MIN_D;
            res_ovf = 1'b1;
        end
    end

    // preset value saturated to the data width
    assign v_ext = A_W'(s_data.value);
    always_comb begin
        preset_val = DW'(v_ext);
        if (v_ext > A_W'(MAX_D))      preset_val = MAX_D;
        else if (v_ext < A_W'(MIN_D)) preset_val = MIN_D;
    end

    // derivative filter: floor of half of (deriv + err - last)
    assign dsum  = (DW+2)'(deriv_reg) + (DW+2)'(err_reg) - (DW+2)'(last_reg);
    assign dhalf = dsum >>> 1;
    always_comb begin
        deriv_new = DW'(dhalf);
        if (dhalf > (DW+2)'(MAX_D))      deriv_new = MAX_D;
        else if (dhalf < (DW+2)'(MIN_D)) deriv_new = MIN_D;
    end

    // integrator: saturating add, then clamp to +/- limit
    assign isum   = (DW+1)'(integ_reg) + (DW+1)'(res);
    assign lim_c  = CW'($signed({1'b0, integ_limit_reg}));
    assign nlim_c = -lim_c;
    always_comb begin
        isat = DW'(isum);
        if (isum > (DW+1)'(MAX_D))      isat = MAX_D;
        else if (isum < (DW+1)'(MIN_D)) isat = MIN_D;
        i_c       = CW'(isat);
        integ_new = isat;
        if (i_c > lim_c)       integ_new = DW'(lim_c);
        else if (i_c < nlim_c) integ_new = DW'(nlim_c);
    end

    // output sum, saturated to the data width and then to 32 bits
    assign ssum = (DW+2)'(pterm_reg) + (DW+2)'(integ_reg) + (DW+2)'(dterm_reg);
    always_comb begin
        s_ovf = 1'b0;
        ssat  = DW'(ssum);
        if (ssum > (DW+2)'(MAX_D)) begin
            ssat  = MAX_D;
            s_ovf = 1'b1;
        end else if (ssum < (DW+2)'(MIN_D)) begin
            ssat  = MIN_D;
            s_ovf = 1'b1;
        end
        s_e   = EW'(ssat);
        d_ovf = 1'b0;
        drive = 32'(s_e);
        if (s_e > EW'(MAX_32)) begin
            drive = MAX_32;
            d_ovf = 1'b1;
        end else if (s_e < EW'(MIN_32)) begin
            drive = MIN_32;
            d_ovf = 1'b1;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg    <= '0;
            err_gain_reg    <= '0;
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            integ_limit_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SETPOINT:    setpoint_reg    <= cfg_data;
                CFG_ERROR_GAIN:  err_gain_reg    <= cfg_data;
                CFG_PROP_GAIN:   prop_gain_reg   <= cfg_data;
                CFG_INTEG_GAIN:  integ_gain_reg  <= cfg_data;
                CFG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data;
                CFG_INTEG_LIMIT: integ_limit_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // regulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= '0;
            integ_reg <= '0;
            deriv_reg <= '0;
        end else begin
            if (ctl.accept && s_data.cmd == CMD_PRESET) integ_reg <= preset_val;
            if (ctl.mul_fin && ctl.phase == PH_INT)     integ_reg <= integ_new;
            if (ctl.dfilt) begin
                deriv_reg <= deriv_new;
                last_reg  <= err_reg;
            end
        end
    end

    // multiplier passes and scratch registers
    always_ff @(posedge aclk) begin
        if (ctl.accept && s_data.cmd == CMD_UPDATE) begin
            diff_reg <= A_W'(s_data.value) - A_W'(setpoint_reg);
            flag_reg <= 1'b0;
        end
        if (ctl.mul_lo) prod_reg <= mul_p;
        if (ctl.mul_hi) begin
            acc_reg  <= prod_reg;
            prod_reg <= mul_p;
        end
        if (ctl.mul_fin) begin
            case (ctl.phase)
                PH_ERR: begin
                    err_reg  <= res;
                    flag_reg <= flag_reg | res_ovf;
                end
                PH_PROP: begin
                    pterm_reg <= res;
                    flag_reg  <= flag_reg | res_ovf;
                end
                PH_DER: begin
                    dterm_reg <= res;
                    flag_reg  <= flag_reg | res_ovf;
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.sum_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.sum_out) begin
            m_data_reg.drive     <= drive;
            m_data_reg.saturated <= flag_reg | s_ovf | d_ovf;
        end
    end

endmodule

/* rtl/pid_regulator_filtered_d.sv */
// ----------------------------------------------------------------------------
// pid_regulator_filtered_d
// Fixed-point PID regulator with a low-pass filtered derivative and a clamped
// integrator; one result beat per update command.
//
//   channel  ports             beat
//   input    s_valid/s_ready   s_data: cmd, value
//   result   m_valid/m_ready   m_data: drive, saturated
//   config   cfg_valid/ready   cfg_index, cfg_data (always ready)
//
// An update must finish before the next beat can be taken: four products
// share one 25x32 multiplier, each as a low slice, a high slice and a combine
// and saturate step, plus a filter step and an output step; a held result
// stalls only the output step. A preset beat loads the integrator and gives
// no result. Reset clears control, config, regulator state and result valid.
// ----------------------------------------------------------------------------
module pid_regulator_filtered_d #(
    parameter int DATA_WIDTH = pidf_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  pidf_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output pidf_pkg::out_item_t            m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pidf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import pidf_pkg::*;

    ctl_t ctl;
    sts_t sts;

    pidf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_data.cmd),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    pidf_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sts       (sts),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
